@@ src/mab_pkg.sv @@
// Shared constants and channel blend function for the mirror alpha blend block.
`timescale 1ns / 1ps
`default_nettype none

package mab_pkg;

    // Row geometry
    localparam int MaxCols   = 2048;
    localparam int HalfDepth = MaxCols / 2;
    localparam int ColW      = $clog2(MaxCols);
    localparam int CntW      = ColW + 1;
    localparam int AddrW     = $clog2(HalfDepth);

    // Pixel layout: blue in the low byte, alpha in the high byte
    localparam int ChW  = 8;
    localparam int PixW = 4 * ChW;

    // Configuration port
    localparam int PaddrW = 3;
    localparam int PdataW = 32;
    localparam int WgtW   = 8;

    // Register indexes, taken from paddr[2]
    localparam logic RegBlendWeight = 1'b0;
    localparam logic RegColCount    = 1'b1;

    // s + trunc(w * (t - s) / 255), working on the magnitude of the difference
    function automatic logic [ChW-1:0] mix_channel(
        input logic [ChW-1:0]  s,
        input logic [ChW-1:0]  t,
        input logic [WgtW-1:0] w
    );
        logic                 neg;
        logic [ChW-1:0]       mag;
        logic [2*ChW-1:0]     prod;
        logic [2*ChW-1:0]     sum;
        logic [ChW-1:0]       q;
        neg  = (t < s);
        mag  = neg ? (s - t) : (t - s);
        prod = {{(2*ChW-WgtW){1'b0}}, w} * {{ChW{1'b0}}, mag};
        // exact floor(x / 255) for x up to 255 * 255
        sum  = prod + (2*ChW)'(1) + {{ChW{1'b0}}, prod[2*ChW-1:ChW]};
        q    = sum[2*ChW-1:ChW];
        return neg ? (s - q) : (s + q);
    endfunction

endpackage

`default_nettype wire

@@ src/mab_if.sv @@
// Valid/ready channel interfaces for input pixels and blended results.
`timescale 1ns / 1ps
`default_nettype none

interface mab_pix_if;
    logic                    valid;
    logic                    ready;
    logic [mab_pkg::ChW-1:0] in_blue;
    logic [mab_pkg::ChW-1:0] in_green;
    logic [mab_pkg::ChW-1:0] in_red;
    logic [mab_pkg::ChW-1:0] in_alpha;

    modport source (output valid, in_blue, in_green, in_red, in_alpha, input ready);
    modport sink   (input valid, in_blue, in_green, in_red, in_alpha, output ready);
endinterface

interface mab_res_if;
    logic                     valid;
    logic                     ready;
    logic [mab_pkg::ColW-1:0] out_column;
    logic [mab_pkg::ChW-1:0]  out_blue;
    logic [mab_pkg::ChW-1:0]  out_green;
    logic [mab_pkg::ChW-1:0]  out_red;
    logic [mab_pkg::ChW-1:0]  out_alpha;
    logic                     last_of_run;

    modport source (output valid, out_column, out_blue, out_green, out_red, out_alpha,
                    last_of_run, input ready);
    modport sink   (input valid, out_column, out_blue, out_green, out_red, out_alpha,
                    last_of_run, output ready);
endinterface

`default_nettype wire

@@ src/mab_row_store.sv @@
// Half-row pixel store: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module mab_row_store (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [mab_pkg::AddrW-1:0] i_wr_addr,
    input  wire logic [mab_pkg::PixW-1:0]  i_wr_data,
    input  wire logic                      i_rd_en,
    input  wire logic [mab_pkg::AddrW-1:0] i_rd_addr,
    output      logic [mab_pkg::PixW-1:0]  o_rd_data
);

    logic [mab_pkg::PixW-1:0] r_mem [mab_pkg::HalfDepth];
    logic [mab_pkg::PixW-1:0] r_rd_data;

    // Store first-half pixels
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Fetch the partner pixel; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ src/mirror_alpha_blend.sv @@
// Top level: alpha blend of each pixel row with its horizontal mirror image.
// Usage:
//   i_pix  carries BGRA pixels of a row in column order (valid/ready).
//   o_res  carries blended results with their column and a last_of_run flag.
//   APB port: register 0 (addr 0) blend_weight, register 1 (addr 4) col_count.
//   Write the registers only while no pixel is in flight.
// Pixels before the row middle are stored and give no result. The middle
// pixel of an odd row comes back unchanged. Each pixel after the middle gives
// two results: the partner column first, then its own column.
// The partner read and the issue register load share the pixel's transfer edge;
// the blend into the output register follows once that register is free, and a
// second result follows the first. Throughput: one pixel per cycle in the first
// half of the row while the issue stage is free; in the second half a pixel is
// taken only as the issue stage sends the last result of the pixel before, since
// the single result register sends one result a cycle while the receiver is ready.
// Reset (synchronous, active low) clears the column position, both channels
// and the registers (weight 0, width 1); store contents stay undefined.
// When the receiver stalls, the output register holds its result and the
// block keeps taking pixels until the held pixel's results back up into the
// issue stage.
`timescale 1ns / 1ps
`default_nettype none

module mirror_alpha_blend (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mab_pix_if.sink                          i_pix,
    mab_res_if.source                        o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mab_pkg::PaddrW-1:0]  paddr,
    input  wire logic [mab_pkg::PdataW-1:0]  pwdata,
    output      logic [mab_pkg::PdataW-1:0]  prdata,
    output      logic                        pready
);

    // Configuration registers
    logic [mab_pkg::WgtW-1:0] r_blend_weight;
    logic [mab_pkg::CntW-1:0] r_col_count;

    // Column tracking
    logic [mab_pkg::ColW-1:0] r_col_pos;
    logic [mab_pkg::ColW-1:0] n_col_pos;
    logic [mab_pkg::CntW-1:0] w_cols;
    logic [mab_pkg::ColW-1:0] w_c;
    logic [mab_pkg::CntW-1:0] w_m_full;
    logic [mab_pkg::ColW-1:0] w_m;
    logic [mab_pkg::CntW-1:0] w_c_inc;
    logic                     w_before;
    logic                     w_middle;
    logic                     w_accept;

    // Issue stage: one pixel whose results are being sent
    logic                     r_s1_valid;
    logic                     r_s1_pair;
    logic                     r_s1_phase;
    logic [mab_pkg::PixW-1:0] r_s1_px;
    logic [mab_pkg::ColW-1:0] r_s1_c;
    logic [mab_pkg::ColW-1:0] r_s1_m;
    logic [mab_pkg::PixW-1:0] w_part;

    // Output register
    logic                     r_out_valid;
    logic [mab_pkg::ColW-1:0] r_out_column;
    logic [mab_pkg::ChW-1:0]  r_out_blue;
    logic [mab_pkg::ChW-1:0]  r_out_green;
    logic [mab_pkg::ChW-1:0]  r_out_red;
    logic [mab_pkg::ChW-1:0]  r_out_alpha;
    logic                     r_out_last;

    logic                     w_out_free;
    logic                     w_s1_fire;
    logic                     w_s1_done;
    logic                     w_cfg_wr;

    logic [mab_pkg::PixW-1:0] w_src;
    logic [mab_pkg::PixW-1:0] w_mir;
    logic [mab_pkg::ColW-1:0] w_col;
    logic                     w_last;

    // APB access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight <= '0;
            r_col_count    <= mab_pkg::CntW'(1);
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                mab_pkg::RegBlendWeight: r_blend_weight <= pwdata[mab_pkg::WgtW-1:0];
                mab_pkg::RegColCount:    r_col_count    <= pwdata[mab_pkg::CntW-1:0];
                default:                 r_blend_weight <= r_blend_weight;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mab_pkg::RegBlendWeight:
                prdata = {{(mab_pkg::PdataW-mab_pkg::WgtW){1'b0}}, r_blend_weight};
            mab_pkg::RegColCount:
                prdata = {{(mab_pkg::PdataW-mab_pkg::CntW){1'b0}}, r_col_count};
            default:
                prdata = '0;
        endcase
    end

    // Effective row width and current column
    always_comb begin
        if (r_col_count == '0) begin
            w_cols = mab_pkg::CntW'(1);
        end else if (r_col_count > mab_pkg::CntW'(mab_pkg::MaxCols)) begin
            w_cols = mab_pkg::CntW'(mab_pkg::MaxCols);
        end else begin
            w_cols = r_col_count;
        end
    end

    // Restart the row when the width shrank to or below the position
    assign w_c      = ({1'b0, r_col_pos} >= w_cols) ? '0 : r_col_pos;
    assign w_m_full = w_cols - mab_pkg::CntW'(1) - {1'b0, w_c};
    assign w_m      = w_m_full[mab_pkg::ColW-1:0];
    assign w_before = (w_c < w_m);
    assign w_middle = (w_c == w_m);
    assign w_c_inc  = {1'b0, w_c} + mab_pkg::CntW'(1);
    assign n_col_pos = (w_c_inc >= w_cols) ? '0 : w_c_inc[mab_pkg::ColW-1:0];

    // Handshake
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_s1_fire   = r_s1_valid && w_out_free;
    assign w_s1_done   = w_s1_fire && (!r_s1_pair || r_s1_phase);
    assign i_pix.ready = !r_s1_valid || w_s1_done;
    assign w_accept    = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
        end else if (w_accept) begin
            r_col_pos <= n_col_pos;
        end
    end

    // Store the first half; fetch the partner for the second half
    mab_row_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && w_before),
        .i_wr_addr (w_c[mab_pkg::AddrW-1:0]),
        .i_wr_data ({i_pix.in_alpha, i_pix.in_red, i_pix.in_green, i_pix.in_blue}),
        .i_rd_en   (w_accept && !w_before && !w_middle),
        .i_rd_addr (w_m[mab_pkg::AddrW-1:0]),
        .o_rd_data (w_part)
    );

    // Issue stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else if (w_accept && !w_before) begin
            r_s1_valid <= 1'b1;
            r_s1_phase <= 1'b0;
        end else if (w_s1_done) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else if (w_s1_fire) begin
            r_s1_phase <= 1'b1;
        end
    end

    // Issue stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_before) begin
            r_s1_pair <= !w_middle;
            r_s1_px   <= {i_pix.in_alpha, i_pix.in_red, i_pix.in_green, i_pix.in_blue};
            r_s1_c    <= w_c;
            r_s1_m    <= w_m;
        end
    end

    // Pick source and mirror pixel for the result being sent
    always_comb begin
        if (!r_s1_pair) begin
            w_src  = r_s1_px;
            w_mir  = r_s1_px;
            w_col  = r_s1_c;
            w_last = 1'b1;
        end else if (!r_s1_phase) begin
            w_src  = w_part;
            w_mir  = r_s1_px;
            w_col  = r_s1_m;
            w_last = 1'b0;
        end else begin
            w_src  = r_s1_px;
            w_mir  = w_part;
            w_col  = r_s1_c;
            w_last = 1'b1;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Blend into the output register
    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_out_column <= w_col;
            r_out_blue   <= mab_pkg::mix_channel(w_src[7:0], w_mir[7:0], r_blend_weight);
            r_out_green  <= mab_pkg::mix_channel(w_src[15:8], w_mir[15:8], r_blend_weight);
            r_out_red    <= mab_pkg::mix_channel(w_src[23:16], w_mir[23:16], r_blend_weight);
            r_out_alpha  <= w_mir[31:24];
            r_out_last   <= w_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_column  = r_out_column;
    assign o_res.out_blue    = r_out_blue;
    assign o_res.out_green   = r_out_green;
    assign o_res.out_red     = r_out_red;
    assign o_res.out_alpha   = r_out_alpha;
    assign o_res.last_of_run = r_out_last;

endmodule

`default_nettype wire

@@ src/mab_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mab_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      i_ready,
    input  wire logic [mab_pkg::ColW-1:0]  i_column,
    input  wire logic [mab_pkg::ChW-1:0]   i_blue,
    input  wire logic                      i_last
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_column) && $stable(i_blue)
                                && $stable(i_last))
        else $error("result changed while stalled");

    // Drop the result channel on reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // The partner result is followed at once by the own-column result
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last |=> i_valid && i_last
                                          && (i_column > $past(i_column)))
        else $error("second result of a pair missing or out of order");

endmodule

bind mirror_alpha_blend mab_checker u_mab_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_column (o_res.out_column),
    .i_blue   (o_res.out_blue),
    .i_last   (o_res.last_of_run)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the mirror alpha blend block: predicted results vs. DUT output.
`timescale 1ns / 1ps

module tb_top;

    localparam int ResetCycles  = 10;
    localparam int SettleCycles = 8;
    localparam int PhaseItems   = 180;

    typedef struct packed {
        logic [mab_pkg::ColW-1:0] column;
        logic [mab_pkg::ChW-1:0]  blue;
        logic [mab_pkg::ChW-1:0]  green;
        logic [mab_pkg::ChW-1:0]  red;
        logic [mab_pkg::ChW-1:0]  alpha;
        logic                     is_last;
    } t_blend_res;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [mab_pkg::PaddrW-1:0] paddr;
    logic [mab_pkg::PdataW-1:0] pwdata;
    logic [mab_pkg::PdataW-1:0] prdata;
    logic                       pready;

    mab_pix_if pix_if();
    mab_res_if res_if();

    mirror_alpha_blend uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted block state and the results still owed by the block
    t_blend_res               pending_blends[$];
    logic [mab_pkg::PixW-1:0] mirror_store [mab_pkg::HalfDepth];
    logic [mab_pkg::WgtW-1:0] blend_wgt;
    logic [mab_pkg::CntW-1:0] width_reg;
    int unsigned              next_col;
    int unsigned              stored_prefix;
    int                       mismatch_count;
    int                       src_idle_pct;
    int                       snk_stall_pct;
    t_blend_res               head_res;
    t_blend_res               seen_res;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned effective_width(input logic [mab_pkg::CntW-1:0] v);
        if (v == '0)
            return 1;
        if (v > mab_pkg::MaxCols)
            return mab_pkg::MaxCols;
        return v;
    endfunction

    // s + w*(t-s)/255 with truncation toward zero
    function automatic logic [mab_pkg::ChW-1:0] blend_channel(
        input logic [mab_pkg::ChW-1:0] s,
        input logic [mab_pkg::ChW-1:0] t
    );
        int diff;
        int q;
        diff = int'(t) - int'(s);
        q    = (int'(blend_wgt) * diff) / 255;
        return mab_pkg::ChW'(int'(s) + q);
    endfunction

    function automatic t_blend_res blend_result(input int unsigned col,
                                                input logic [mab_pkg::PixW-1:0] src,
                                                input logic [mab_pkg::PixW-1:0] mir,
                                                input logic is_last);
        t_blend_res r;
        r.column  = mab_pkg::ColW'(col);
        r.blue    = blend_channel(src[7:0],   mir[7:0]);
        r.green   = blend_channel(src[15:8],  mir[15:8]);
        r.red     = blend_channel(src[23:16], mir[23:16]);
        r.alpha   = mir[31:24];
        r.is_last = is_last;
        return r;
    endfunction

    // Advance the column position and queue the results one pixel causes
    function automatic void predict_blend(input logic [mab_pkg::PixW-1:0] px);
        int unsigned              cols;
        int unsigned              c;
        int unsigned              m;
        logic [mab_pkg::PixW-1:0] partner;
        cols = effective_width(width_reg);
        if (next_col >= cols)
            next_col = 0;
        c = next_col;
        m = cols - 1 - c;
        if (c < m) begin
            if (c < mab_pkg::HalfDepth) begin
                mirror_store[c] = px;
                if (c + 1 > stored_prefix)
                    stored_prefix = c + 1;
            end
        end else if (c == m) begin
            pending_blends.push_back(blend_result(c, px, px, 1'b1));
        end else begin
            partner = (m < mab_pkg::HalfDepth) ? mirror_store[m] : '0;
            pending_blends.push_back(blend_result(m, partner, px, 1'b0));
            pending_blends.push_back(blend_result(c, px, partner, 1'b1));
        end
        next_col = (c + 1 >= cols) ? 0 : c + 1;
    endfunction

    // A new width is safe if it restarts the row or every partner it reads was stored
    function automatic bit width_change_safe(input logic [mab_pkg::CntW-1:0] v);
        return (next_col >= effective_width(v)) || (next_col <= stored_prefix);
    endfunction

    // Receiver: stall at random
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen_res = '{res_if.out_column, res_if.out_blue, res_if.out_green,
                         res_if.out_red, res_if.out_alpha, res_if.last_of_run};
            if (pending_blends.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual col %0d bgra %h %h %h %h last %b",
                         $time, seen_res.column, seen_res.blue, seen_res.green,
                         seen_res.red, seen_res.alpha, seen_res.is_last);
                mismatch_count++;
            end else begin
                head_res = pending_blends.pop_front();
                if (seen_res !== head_res) begin
                    $display("%0t: mismatch, expected col %0d bgra %h %h %h %h last %b",
                             $time, head_res.column, head_res.blue, head_res.green,
                             head_res.red, head_res.alpha, head_res.is_last);
                    $display("%0t:           actual   col %0d bgra %h %h %h %h last %b",
                             $time, seen_res.column, seen_res.blue, seen_res.green,
                             seen_res.red, seen_res.alpha, seen_res.is_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one pixel, idling first at random, and predict it once transferred
    task automatic push_pixel(input logic [mab_pkg::PixW-1:0] px);
        if ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        pix_if.valid    <= 1'b1;
        pix_if.in_blue  <= px[7:0];
        pix_if.in_green <= px[15:8];
        pix_if.in_red   <= px[23:16];
        pix_if.in_alpha <= px[31:24];
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        predict_blend(px);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty
    task automatic finish_inflight();
        pix_if.valid <= 1'b0;
        while (pending_blends.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // APB write: setup, then access until pready
    task automatic write_reg(input logic idx, input logic [mab_pkg::PdataW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == mab_pkg::RegBlendWeight)
            blend_wgt = val[mab_pkg::WgtW-1:0];
        else
            width_reg = val[mab_pkg::CntW-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [mab_pkg::WgtW-1:0] wgt,
                              input logic [mab_pkg::CntW-1:0] width);
        finish_inflight();
        write_reg(mab_pkg::RegBlendWeight, mab_pkg::PdataW'(wgt));
        write_reg(mab_pkg::RegColCount, mab_pkg::PdataW'(width));
    endtask

    // Reset values: weight 0 and one-pixel rows, so each pixel is its own middle
    task automatic test_reset_state();
        push_pixel(32'h0000_0000);
        push_pixel(32'hFFFF_FFFF);
    endtask

    // Full and zero weight with channel differences of both signs
    task automatic test_weight_extremes();
        set_config(8'd255, 12'd2);
        push_pixel(32'hFF00_FF00);
        push_pixel(32'h00FF_00FF);
        set_config(8'd0, 12'd2);
        push_pixel(32'h12FF_00A5);
        push_pixel(32'hED00_FF5A);
    endtask

    task automatic test_odd_row_middle();
        set_config(8'd128, 12'd5);
        push_pixel(32'h0000_0000);
        push_pixel(32'hFFFF_FFFF);
        push_pixel(32'h80C0_4020);
        push_pixel(32'h0102_0304);
        push_pixel(32'hFEFD_FCFB);
    endtask

    // A width of zero acts as one pixel per row
    task automatic test_width_out_of_range();
        set_config(8'd200, 12'd0);
        push_pixel(32'hA5A5_5A5A);
        push_pixel(32'h5A5A_A5A5);
    endtask

    // Shrink the width past the current column: the next pixel starts a new row
    task automatic test_width_change_mid_row();
        set_config(8'd77, 12'd10);
        repeat (4) push_pixel($urandom());
        finish_inflight();
        write_reg(mab_pkg::RegColCount, 32'd3);
        repeat (3) push_pixel($urandom());
        set_config(8'd77, 12'd6);
        repeat (4) push_pixel($urandom());
        finish_inflight();
        write_reg(mab_pkg::RegColCount, 32'd2);
        repeat (2) push_pixel($urandom());
    endtask

    // Widest rows, above the maximum and exactly at it: store a prefix of the
    // row, then shrink the width so the next pixels read that prefix back
    task automatic test_widest_rows();
        set_config(8'd255, 12'hFFF);
        repeat (6) push_pixel($urandom());
        finish_inflight();
        write_reg(mab_pkg::RegColCount, 32'd12);
        repeat (6) push_pixel($urandom());
        set_config(8'd90, 12'(mab_pkg::MaxCols));
        repeat (4) push_pixel($urandom());
        finish_inflight();
        write_reg(mab_pkg::RegColCount, 32'd8);
        repeat (4) push_pixel($urandom());
    endtask

    // Random rows with reconfiguration at row ends and now and then mid-row
    task automatic test_random_traffic(input int items, input int src_pct, input int snk_pct);
        int                         sent;
        logic [mab_pkg::PdataW-1:0] junk;
        logic [mab_pkg::WgtW-1:0]   wgt;
        logic [mab_pkg::CntW-1:0]   width;
        int                         pick;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < items) begin
            if ((next_col == 0 && $urandom_range(2) == 0) || $urandom_range(59) == 0) begin
                finish_inflight();
                junk = $urandom();
                case ($urandom_range(3))
                    0:       wgt = 8'd0;
                    1:       wgt = 8'd255;
                    default: wgt = mab_pkg::WgtW'($urandom());
                endcase
                if ($urandom_range(3) != 0)
                    write_reg(mab_pkg::RegBlendWeight, {junk[mab_pkg::PdataW-1:mab_pkg::WgtW], wgt});
                pick = $urandom_range(99);
                if (pick < 70)
                    width = mab_pkg::CntW'($urandom_range(12, 1));
                else if (pick < 90)
                    width = mab_pkg::CntW'($urandom_range(64, 13));
                else if (pick < 98)
                    width = mab_pkg::CntW'($urandom_range(300, 65));
                else
                    width = '0;
                if (width_change_safe(width))
                    write_reg(mab_pkg::RegColCount, {junk[mab_pkg::PdataW-1:mab_pkg::CntW], width});
            end
            push_pixel($urandom());
            sent++;
        end
        finish_inflight();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pix_if.valid    = 1'b0;
        pix_if.in_blue  = '0;
        pix_if.in_green = '0;
        pix_if.in_red   = '0;
        pix_if.in_alpha = '0;
        res_if.ready    = 1'b0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        mismatch_count  = 0;
        blend_wgt       = '0;
        width_reg       = mab_pkg::CntW'(1);
        next_col        = 0;
        stored_prefix   = 0;

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_weight_extremes();
        test_odd_row_middle();
        test_width_out_of_range();
        test_width_change_mid_row();
        test_widest_rows();
        test_random_traffic(PhaseItems, 0, 0);
        test_random_traffic(PhaseItems, 70, 0);
        test_random_traffic(PhaseItems, 0, 70);
        test_random_traffic(PhaseItems, 14, 14);

        finish_inflight();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
